// ===== hdl/multi_slot_countdown_timer_macros.svh =====
// Assertion helpers used by the timer bank top level.
// Both expect clk and rst_n in scope.
`ifndef MULTI_SLOT_COUNTDOWN_TIMER_MACROS_SVH
`define MULTI_SLOT_COUNTDOWN_TIMER_MACROS_SVH

// same-cycle implication
`define MSCT_ASSERT_NOW(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("timer bank check failed");

// next-cycle implication
`define MSCT_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("timer bank check failed");

`endif

// ===== hdl/msct_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msct_pkg;

    localparam int NUM_SLOTS_DEF   = 16;
    localparam int MS_PER_TICK_DEF = 10;
    localparam int MAX_REPORTS     = 16;

    localparam int MODE_W    = 3;
    localparam int SLOT_W    = 4;
    localparam int PERIOD_W  = 32;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 29;
    localparam int REP_W     = $clog2(MAX_REPORTS + 1);
    localparam int DIV_STEPS = 2;   // reciprocal multiply, then remainder
    localparam int DIV_CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SET    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_START  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STOP   = 3'd3;
    localparam logic [MODE_W-1:0] MODE_RELOAD = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXPIRED  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECTED = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request
        logic div_step;  // one step of ms -> ticks division
        logic cmd_read;  // read slot entry for a command
        logic exec;      // apply command, write its result
        logic scan_en;   // tick scan runs
        logic flush;     // emit held expiry as last
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_tick;
        logic in_set;
        logic in_cmd;
        logic div_last;
        logic out_free;
        logic scan_done;
        logic pend_valid;
    } ctrl_sts_t;

endpackage

`default_nettype wire

// ===== hdl/msct_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface msct_req_if import msct_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period_ms;

    modport source (output valid, output mode, output slot, output period_ms, input ready);
    modport sink   (input valid, input mode, input slot, input period_ms, output ready);
endinterface

interface msct_res_if import msct_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_out;
    logic                last;

    modport source (output valid, output status, output slot_out, output last, input ready);
    modport sink   (input valid, input status, input slot_out, input last, output ready);
endinterface

`default_nettype wire

// ===== hdl/msct_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/msct_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msct_ctrl import msct_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ctrl_sts_t  sts,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_RD    = 6'b000100,
        S_CMD   = 6'b001000,
        S_SCAN  = 6'b010000,
        S_FLUSH = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    if (sts.in_tick)
                        state_next = S_SCAN;
                    else if (sts.in_set)
                        state_next = S_DIV;
                    else if (sts.in_cmd)
                        state_next = S_RD;
                    else
                        state_next = S_CMD;   // rejected request
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                    state_next = S_CMD;
            end
            S_RD:
            begin
                cmd.cmd_read = 1'b1;
                state_next   = S_CMD;
            end
            S_CMD:
            begin
                if (sts.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (sts.scan_done)
                    state_next = sts.pend_valid ? S_FLUSH : S_IDLE;
            end
            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/msct_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msct_dp import msct_pkg::*; #(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int MS_PER_TICK = MS_PER_TICK_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  ctrl_cmd_t           cmd,
    output ctrl_sts_t           sts,
    input  logic [MODE_W-1:0]   in_mode,
    input  logic [SLOT_W-1:0]   in_slot,
    input  logic [PERIOD_W-1:0] in_period_ms,
    input  logic                out_ready,
    output logic                out_valid,
    output logic [STATUS_W-1:0] out_status,
    output logic [SLOT_W-1:0]   out_slot,
    output logic                out_last
);

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CW = $clog2(NUM_SLOTS + 1);
    localparam int DW = $clog2(MS_PER_TICK + 1);
    localparam int EW = 2 * COUNT_W;
    localparam int PROD_W = 2 * PERIOD_W;
    localparam logic [DW-1:0] DIVISOR = DW'(MS_PER_TICK);
    localparam logic [PERIOD_W-1:0] RECIP =
        PERIOD_W'(PROD_W'({PERIOD_W{1'b1}}) / PROD_W'(MS_PER_TICK));

    // request decode
    logic in_slot_ok;
    assign in_slot_ok = (32'(in_slot) < NUM_SLOTS);

    logic [MODE_W-1:0] mode_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              bad_reg;
    logic [IW-1:0]     slot_idx;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_mode;
            slot_reg <= in_slot;
            bad_reg  <= !(sts.in_tick || sts.in_set || sts.in_cmd);
        end
    end

    assign slot_idx = IW'(slot_reg);

    // ms -> ticks by reciprocal multiplication; the estimate is low by at most
    // one and the remainder step corrects it
    logic [PERIOD_W-1:0]  num_reg;
    logic [PERIOD_W-1:0]  est_reg;
    logic [DW:0]          rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [PROD_W-1:0]    prod;
    logic [PERIOD_W-1:0]  diff;
    logic [PERIOD_W-1:0]  quo;
    logic [COUNT_W-1:0]   ticks;

    assign prod  = PROD_W'(num_reg) * PROD_W'(RECIP);
    assign diff  = num_reg - est_reg * PERIOD_W'(DIVISOR);
    assign quo   = est_reg + PERIOD_W'(rem_reg >= {1'b0, DIVISOR});
    assign ticks = (quo > PERIOD_W'(COUNT_MAX)) ? COUNT_MAX : quo[COUNT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            num_reg     <= in_period_ms;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_cnt_reg == '0)
                est_reg <= prod[PROD_W-1:PERIOD_W];
            else
                rem_reg <= diff[DW:0];
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    // slot store: {reload, remaining}, masked to zero until first written
    logic                 ram_we;
    logic [IW-1:0]        ram_waddr;
    logic [EW-1:0]        ram_wdata;
    logic                 ram_re;
    logic [IW-1:0]        ram_raddr;
    logic [EW-1:0]        ram_rdata;
    logic [NUM_SLOTS-1:0] valid_reg;
    logic [NUM_SLOTS-1:0] running_reg;
    logic                 rd_vld_reg;
    logic [EW-1:0]        entry;
    logic [COUNT_W-1:0]   ent_reload;
    logic [COUNT_W-1:0]   ent_remain;

    msct_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_SLOTS),
        .AW    (IW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign entry      = rd_vld_reg ? ram_rdata : '0;
    assign ent_reload = entry[EW-1:COUNT_W];
    assign ent_remain = entry[COUNT_W-1:0];

    // tick scan: one slot issued per cycle unless held for result room, evaluated when its read returns
    logic [CW-1:0]      cnt_reg;
    logic               s1_valid_reg;
    logic               s1_run_reg;
    logic [IW-1:0]      s1_idx_reg;
    logic [REP_W-1:0]   rep_cnt_reg;
    logic               pend_valid_reg;
    logic [SLOT_W-1:0]  pend_slot_reg;
    logic               scan_more;
    logic [COUNT_W-1:0] dec;
    logic               s1_hit;
    logic               s1_report;
    logic               out_free;
    logic               advance;
    logic               scan_go;
    logic               scan_wr;
    logic               push_pend;

    assign scan_more = (cnt_reg < CW'(NUM_SLOTS));
    assign dec       = ent_remain - COUNT_W'(1);
    assign s1_hit    = s1_valid_reg && s1_run_reg && (dec == '0);
    assign s1_report = s1_hit && (rep_cnt_reg < REP_W'(MAX_REPORTS));
    assign out_free  = !out_valid || out_ready;
    // a new expiry pushes the held one out; hold the scan if there is no room
    assign advance   = !(s1_report && pend_valid_reg && !out_free);
    assign scan_go   = cmd.scan_en && advance;
    assign scan_wr   = scan_go && s1_valid_reg && s1_run_reg;
    assign push_pend = scan_go && s1_report && pend_valid_reg;

    // command execution
    logic                exec_ok;
    logic                exec_set;
    logic                exec_start;
    logic                exec_stop;
    logic                exec_reload;
    logic [STATUS_W-1:0] exec_status;

    assign exec_ok     = cmd.exec && !bad_reg;
    assign exec_set    = exec_ok && (mode_reg == MODE_SET) && (quo != '0);
    assign exec_start  = exec_ok && (mode_reg == MODE_START);
    assign exec_stop   = exec_ok && (mode_reg == MODE_STOP);
    assign exec_reload = exec_ok && (mode_reg == MODE_RELOAD);
    assign exec_status = (bad_reg || ((mode_reg == MODE_SET) && (quo == '0))) ?
                         ST_REJECTED : ST_DONE;

    always_comb
    begin
        ram_re    = cmd.cmd_read || (scan_go && scan_more);
        ram_raddr = cmd.cmd_read ? slot_idx : cnt_reg[IW-1:0];
        ram_we    = exec_set || exec_reload || scan_wr;
        ram_waddr = scan_wr ? s1_idx_reg : slot_idx;
        if (exec_set)
            ram_wdata = {ticks, ticks};
        else if (exec_reload || s1_hit)
            ram_wdata = {ent_reload, ent_reload};
        else
            ram_wdata = {ent_reload, dec};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            running_reg <= '0;
            rd_vld_reg  <= 1'b0;
        end
        else
        begin
            if (ram_re)
                rd_vld_reg <= valid_reg[ram_raddr];
            if (ram_we)
                valid_reg[ram_waddr] <= 1'b1;
            if (exec_set || exec_stop)
                running_reg[slot_idx] <= 1'b0;
            else if (exec_start)
                running_reg[slot_idx] <= 1'b1;
            if (scan_wr && s1_hit)
                running_reg[s1_idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            s1_run_reg     <= 1'b0;
            s1_idx_reg     <= '0;
            rep_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            pend_slot_reg  <= '0;
        end
        else if (cmd.load)
        begin
            cnt_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            rep_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (scan_go)
        begin
            if (scan_more)
            begin
                cnt_reg      <= cnt_reg + CW'(1);
                s1_valid_reg <= 1'b1;
                s1_idx_reg   <= cnt_reg[IW-1:0];
                s1_run_reg   <= running_reg[cnt_reg[IW-1:0]];
            end
            else
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_report)
            begin
                rep_cnt_reg    <= rep_cnt_reg + REP_W'(1);
                pend_valid_reg <= 1'b1;
                pend_slot_reg  <= SLOT_W'(s1_idx_reg);
            end
        end
        else if (cmd.flush)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        sts.in_tick    = (in_mode == MODE_TICK);
        sts.in_set     = (in_mode == MODE_SET) && in_slot_ok;
        sts.in_cmd     = ((in_mode == MODE_START) || (in_mode == MODE_STOP) ||
                          (in_mode == MODE_RELOAD)) && in_slot_ok;
        sts.div_last   = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
        sts.out_free   = out_free;
        sts.scan_done  = !scan_more && !s1_valid_reg;
        sts.pend_valid = pend_valid_reg;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (cmd.exec || push_pend || cmd.flush)
        begin
            out_valid <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_status <= exec_status;
            out_slot   <= slot_reg;
            out_last   <= 1'b1;
        end
        else if (push_pend || cmd.flush)
        begin
            out_status <= ST_EXPIRED;
            out_slot   <= pend_slot_reg;
            out_last   <= cmd.flush;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/multi_slot_countdown_timer.sv =====
// Request accept to result register: start/stop/reload read the slot store, then execute;
// a reject executes directly; set first runs the ms-to-ticks divide (reciprocal multiply,
// then remainder correction). Tick: one slot store read per cycle unless the scan waits
// for result room; the last expiry goes out after the scan. One request in flight: a new
// one is accepted only in idle, and execution and flush wait on result back-pressure.
// Reset clears running and written flags at once; unwritten slots read as zero counts.
`timescale 1ns / 1ps
`default_nettype none

`include "multi_slot_countdown_timer_macros.svh"

module multi_slot_countdown_timer import msct_pkg::*; #(
    parameter int NUM_SLOTS   = NUM_SLOTS_DEF,
    parameter int MS_PER_TICK = MS_PER_TICK_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    msct_req_if.sink  req,
    msct_res_if.source res
);

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    msct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    msct_dp #(
        .NUM_SLOTS   (NUM_SLOTS),
        .MS_PER_TICK (MS_PER_TICK)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_mode      (req.mode),
        .in_slot      (req.slot),
        .in_period_ms (req.period_ms),
        .out_ready    (res.ready),
        .out_valid    (res.valid),
        .out_status   (res.status),
        .out_slot     (res.slot_out),
        .out_last     (res.last)
    );

    `MSCT_ASSERT_NEXT(a_one_request, req.valid && req.ready, !req.ready)
    `MSCT_ASSERT_NOW(a_result_room, cmd.exec || cmd.flush, sts.out_free)
    `MSCT_ASSERT_NOW(a_flush_held, cmd.flush, sts.pend_valid && !cmd.scan_en)
    `MSCT_ASSERT_NOW(a_not_last_expiry, res.valid && !res.last, res.status == ST_EXPIRED)

endmodule

`default_nettype wire

// ===== verif/multi_slot_countdown_timer_tb.sv =====
`timescale 1ns / 1ps

module multi_slot_countdown_timer_tb;
    import msct_pkg::*;

    localparam int NUM_SLOTS     = NUM_SLOTS_DEF;
    localparam int MS_PER_TICK   = MS_PER_TICK_DEF;
    localparam int RANDOM_ITEMS  = 150;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = NUM_SLOTS + 8;
    localparam int CYCLE_LIMIT   = 400_000;
    localparam int MAX_PRINTS    = 40;

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_out;
        logic                last;
    } timer_res_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    msct_req_if req ();
    msct_res_if res ();

    multi_slot_countdown_timer #(
        .NUM_SLOTS   (NUM_SLOTS),
        .MS_PER_TICK (MS_PER_TICK)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .res   (res)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // shadow copy of the timer bank
    logic [COUNT_W-1:0] shadow_reload [NUM_SLOTS];
    logic [COUNT_W-1:0] shadow_remain [NUM_SLOTS];
    logic               shadow_running [NUM_SLOTS];

    timer_res_t  pending_results [$];
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned items_sent   = 0;
    int unsigned burst_left   = 0;
    bit          steady_send  = 1'b0;
    bit          hold_arm     = 1'b0;
    int unsigned hold_left    = 0;
    int unsigned rx_count     = 0;
    int unsigned rx_style     = 0;

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTS)
        begin
            $display("ERROR at %0t: %s", $time, what);
        end
        error_count++;
    endtask

    task automatic predict_timer_bank(input logic [MODE_W-1:0] mode,
                                      input logic [SLOT_W-1:0] slot,
                                      input logic [PERIOD_W-1:0] period_ms);
        logic [PERIOD_W-1:0] ticks;
        logic [STATUS_W-1:0] status;
        int                  expired [$];
        begin
            status = ST_DONE;
            if (mode == MODE_TICK)
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (shadow_running[i])
                    begin
                        shadow_remain[i] = shadow_remain[i] - 1'b1;
                        if (shadow_remain[i] == '0)
                        begin
                            shadow_running[i] = 1'b0;
                            shadow_remain[i]  = shadow_reload[i];
                            if (expired.size() < MAX_REPORTS)
                            begin
                                expired.push_back(i);
                            end
                        end
                    end
                end
                foreach (expired[k])
                begin
                    pending_results.push_back('{ST_EXPIRED, SLOT_W'(expired[k]),
                                                k == expired.size() - 1});
                end
            end
            else if (mode > MODE_RELOAD || slot >= NUM_SLOTS)
            begin
                pending_results.push_back('{ST_REJECTED, slot, 1'b1});
            end
            else
            begin
                case (mode)
                    MODE_SET:
                    begin
                        ticks = period_ms / MS_PER_TICK;
                        if (ticks == '0)
                        begin
                            status = ST_REJECTED;
                        end
                        else
                        begin
                            if (ticks > PERIOD_W'(COUNT_MAX))
                            begin
                                ticks = PERIOD_W'(COUNT_MAX);
                            end
                            shadow_reload[slot]  = ticks[COUNT_W-1:0];
                            shadow_remain[slot]  = ticks[COUNT_W-1:0];
                            shadow_running[slot] = 1'b0;
                        end
                    end
                    MODE_START:  shadow_running[slot] = 1'b1;
                    MODE_STOP:   shadow_running[slot] = 1'b0;
                    default:     shadow_remain[slot]  = shadow_reload[slot];
                endcase
                pending_results.push_back('{status, slot, 1'b1});
            end
        end
    endtask

    // Sender: bursts of random length with random gaps, unless steady_send.
    task automatic send_request(input logic [MODE_W-1:0] mode,
                                input logic [SLOT_W-1:0] slot,
                                input logic [PERIOD_W-1:0] period_ms);
        int unsigned gap;
        begin
            if (burst_left == 0)
            begin
                gap        = steady_send ? 0 : $urandom_range(0, 6);
                burst_left = $urandom_range(1, 8);
                repeat (gap)
                begin
                    @(negedge clk);
                    req.valid <= 1'b0;
                end
            end
            burst_left--;
            @(negedge clk);
            req.valid     <= 1'b1;
            req.mode      <= mode;
            req.slot      <= slot;
            req.period_ms <= period_ms;
            do
            begin
                @(posedge clk);
            end
            while (!req.ready);
            predict_timer_bank(mode, slot, period_ms);
            items_sent++;
        end
    endtask

    // Stop offering and let every outstanding result come back; a tick with
    // no expiry keeps the block busy without a result, hence the settle time.
    task automatic wait_results_drained();
        @(negedge clk);
        req.valid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic test_command_rejects();
        send_request(MODE_TICK, 4'd0, 32'd0);
        send_request(MODE_SET, 4'd0, 32'd0);
        send_request(MODE_SET, 4'd0, 32'd9);
        for (int m = MODE_RELOAD + 1; m < 2 ** MODE_W; m++)
        begin
            send_request(MODE_W'(m), 4'd7, PERIOD_MAX);
        end
        wait_results_drained();
    endtask

    task automatic test_one_shot_flow();
        send_request(MODE_SET, 4'd15, PERIOD_MAX);
        send_request(MODE_START, 4'd15, 32'd0);
        send_request(MODE_SET, 4'd15, 32'd20);     // set stops a running slot
        send_request(MODE_SET, 4'd1, 32'd25);
        send_request(MODE_START, 4'd1, 32'd0);
        send_request(MODE_START, 4'd1, 32'd0);     // already running
        send_request(MODE_TICK, 4'd0, 32'd0);
        send_request(MODE_STOP, 4'd1, 32'd0);
        send_request(MODE_STOP, 4'd1, 32'd0);      // already stopped
        send_request(MODE_TICK, 4'd0, 32'd0);
        send_request(MODE_START, 4'd1, 32'd0);     // resumes at one tick left
        send_request(MODE_START, 4'd3, 32'd0);     // never set: count wraps
        send_request(MODE_TICK, 4'd0, 32'd0);
        send_request(MODE_SET, 4'd3, 32'd10);
        wait_results_drained();
    endtask

    task automatic test_reload_keeps_running();
        send_request(MODE_SET, 4'd2, 32'd30);
        send_request(MODE_START, 4'd2, 32'd0);
        send_request(MODE_TICK, 4'd0, 32'd0);
        send_request(MODE_RELOAD, 4'd2, 32'd0);
        repeat (3) send_request(MODE_TICK, 4'd0, 32'd0);
        wait_results_drained();
    endtask

    // Every slot is set and started in shuffled order; on the first pass all expire on one tick.
    task automatic test_all_slots_expire();
        int order [NUM_SLOTS];
        int j;
        int t;
        begin
            for (int pass = 0; pass < 3; pass++)
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    order[i] = i;
                    send_request(MODE_SET, SLOT_W'(i),
                                 pass == 0 ? $urandom_range(10, 19) : $urandom_range(10, 39));
                end
                for (int i = NUM_SLOTS - 1; i > 0; i--)
                begin
                    j        = $urandom_range(0, i);
                    t        = order[i];
                    order[i] = order[j];
                    order[j] = t;
                end
                foreach (order[i])
                begin
                    send_request(MODE_START, SLOT_W'(order[i]), $urandom);
                end
                repeat (3) send_request(MODE_TICK, SLOT_W'($urandom), $urandom);
            end
            wait_results_drained();
        end
    endtask

    // Receiver stalls for a long stretch while requests keep coming.
    task automatic test_result_holdoff();
        steady_send = 1'b1;
        @(negedge clk);
        req.valid <= 1'b0;
        hold_arm = 1'b1;
        for (int i = 0; i < 6; i++)
        begin
            send_request(MODE_SET, SLOT_W'(i), $urandom_range(10, 25));
            send_request(MODE_START, SLOT_W'(i), 32'd0);
        end
        repeat (4) send_request(MODE_TICK, 4'd0, 32'd0);
        steady_send = 1'b0;
        wait_results_drained();
    endtask

    task automatic test_random_mix();
        logic [SLOT_W-1:0] picked [$];
        int unsigned       target;
        int unsigned       pick;
        begin
            target = items_sent + RANDOM_ITEMS;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 7) == 0)
                begin
                    steady_send = !steady_send;
                end
                if ($urandom_range(0, 9) < 6)
                begin
                    // arm a few slots with short periods, then tick them out
                    picked.delete();
                    repeat ($urandom_range(1, 5)) picked.push_back(SLOT_W'($urandom));
                    foreach (picked[k])
                    begin
                        send_request(MODE_SET, picked[k], $urandom_range(10, 59));
                    end
                    picked.shuffle();
                    foreach (picked[k])
                    begin
                        send_request(MODE_START, picked[k], $urandom);
                    end
                    repeat ($urandom_range(1, 6))
                    begin
                        pick = $urandom_range(0, 9);
                        if (pick == 0)
                        begin
                            send_request(MODE_STOP, picked[$urandom_range(0, picked.size() - 1)],
                                         $urandom);
                        end
                        else if (pick == 1)
                        begin
                            send_request(MODE_RELOAD,
                                         picked[$urandom_range(0, picked.size() - 1)], $urandom);
                        end
                        send_request(MODE_TICK, SLOT_W'($urandom), $urandom);
                    end
                end
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       pick = $urandom;
                        1:       pick = $urandom_range(0, MS_PER_TICK - 1);
                        default: pick = $urandom_range(MS_PER_TICK, 99);
                    endcase
                    send_request(MODE_W'($urandom), SLOT_W'($urandom), pick);
                end
            end
            wait_results_drained();
        end
    endtask

    // long hold-off, counted in its own process
    always @(posedge clk)
    begin
        if (hold_arm)
        begin
            hold_left <= HOLD_CYCLES;
            hold_arm  <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge clk)
    begin
        rx_count <= rx_count + 1;
        if (rx_count % 97 == 0)
        begin
            rx_style <= $urandom_range(0, 3);
        end
        if (hold_left != 0)
        begin
            res.ready <= 1'b0;
        end
        else
        begin
            case (rx_style)
                0:       res.ready <= 1'b1;
                1:       res.ready <= 1'($urandom_range(0, 1));
                2:       res.ready <= ($urandom_range(0, 3) == 0);
                default: res.ready <= (rx_count % 5 != 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : result_check
        timer_res_t want;
        if (rst_n && res.valid && res.ready)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result status=%0d slot=%0d last=%0b",
                                          res.status, res.slot_out, res.last));
            end
            else
            begin
                want = pending_results.pop_front();
                if (res.status !== want.status)
                begin
                    report_mismatch($sformatf("status %0d, want %0d (slot %0d)",
                                              res.status, want.status, want.slot_out));
                end
                if (res.slot_out !== want.slot_out)
                begin
                    report_mismatch($sformatf("slot_out %0d, want %0d",
                                              res.slot_out, want.slot_out));
                end
                if (res.last !== want.last)
                begin
                    report_mismatch($sformatf("last %0b, want %0b (slot %0d)",
                                              res.last, want.last, want.slot_out));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("multi_slot_countdown_timer: mismatch");
            $finish;
        end
    end

    initial
    begin
        req.valid     = 1'b0;
        req.mode      = MODE_TICK;
        req.slot      = '0;
        req.period_ms = '0;
        res.ready     = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            shadow_reload[i]  = '0;
            shadow_remain[i]  = '0;
            shadow_running[i] = 1'b0;
        end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_command_rejects();
        test_one_shot_flow();
        test_reload_keeps_running();
        test_all_slots_expire();
        test_result_holdoff();
        test_random_mix();

        if (error_count == 0)
        begin
            $display("multi_slot_countdown_timer: match");
        end
        else
        begin
            $display("multi_slot_countdown_timer: mismatch");
        end
        $finish;
    end

endmodule
